[hdl/hav_pkg.sv]
// Package for the haversine distance block: fixed-point constants, arctangent table and helpers.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package hav_pkg;

    localparam int CORDIC_STAGES = 28;
    localparam int FRAC_BITS = 30;
    // Working width of CORDIC datapaths: sign, three integer bits, fraction.
    localparam int CW = FRAC_BITS + 4;
    localparam int SQ_W = 2 * FRAC_BITS + 2;
    localparam int ROOT_STEPS = FRAC_BITS + 1;

    localparam logic [CW-1:0] ONE_Q = CW'(64'd1 << FRAC_BITS);
    // Radians per microdegree at 62 fraction bits: floor(pi * 2^62 / 180e6).
    localparam logic [39:0] RAD_PER_UDEG = 40'd80489105089;
    localparam logic [CW-1:0] GAIN_Q = CW'(64'd652032874);
    localparam logic [CW-1:0] HALF_PI_Q = CW'(64'd1686629713);
    localparam logic [24:0] TWO_R = 25'd12742000;

    localparam logic [29:0] UDEG_FULL = 30'd360000000;
    localparam logic [29:0] UDEG_HALF = 30'd180000000;
    localparam logic [29:0] UDEG_QUARTER = 30'd90000000;

    // Arctangent of 2^-i at 30 fraction bits.
    function automatic logic [CW-1:0] atan_q(input int i);
        logic [31:0] v;
        begin
            case (i)
                0: v = 32'd843314857;
                1: v = 32'd497837829;
                2: v = 32'd263043837;
                3: v = 32'd133525159;
                4: v = 32'd67021687;
                5: v = 32'd33543516;
                6: v = 32'd16775851;
                7: v = 32'd8388437;
                8: v = 32'd4194283;
                9: v = 32'd2097149;
                10: v = 32'd1048576;
                11: v = 32'd524288;
                12: v = 32'd262144;
                13: v = 32'd131072;
                14: v = 32'd65536;
                15: v = 32'd32768;
                16: v = 32'd16384;
                17: v = 32'd8192;
                18: v = 32'd4096;
                19: v = 32'd2048;
                20: v = 32'd1024;
                21: v = 32'd512;
                22: v = 32'd256;
                23: v = 32'd128;
                24: v = 32'd64;
                25: v = 32'd32;
                26: v = 32'd16;
                27: v = 32'd8;
                default: v = 32'd0;
            endcase
            atan_q = CW'(v);
        end
    endfunction

    // Clamp a CORDIC output to the range 0 to 1.
    function automatic logic [FRAC_BITS:0] clamp_one(input logic signed [CW-1:0] v);
        begin
            if (v < 0)
                clamp_one = '0;
            else if (v > $signed(ONE_Q))
                clamp_one = (FRAC_BITS+1)'(ONE_Q);
            else
                clamp_one = v[FRAC_BITS:0];
        end
    endfunction

endpackage
`default_nettype wire

[hdl/hav_front.sv]
// Angle front end: differences, fold into 0..180 degrees, conversion to radians.
// Depends on hav_pkg. Three register stages with valid bits and a shared enable.
`default_nettype none
module hav_front
    import hav_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [27:0]   lat_a,
    input  wire logic signed [28:0]   lon_a,
    input  wire logic signed [27:0]   lat_b,
    input  wire logic signed [28:0]   lon_b,
    output logic                      out_valid,
    output logic [CW-1:0]             th_dlat,
    output logic [CW-1:0]             th_dlon,
    output logic [CW-1:0]             th_la,
    output logic [CW-1:0]             th_lb,
    output logic                      neg_diff
);

    logic [2:0] v_reg;
    logic signed [30:0] d_reg [4];
    logic [29:0] f_reg [4];
    logic [1:0] n_reg;
    logic [CW-1:0] t_reg [4];
    logic nd_reg;

    // Fold an angle in microdegrees into 0..180 by period and even symmetry.
    function automatic logic [29:0] fold(input logic signed [30:0] d);
        logic signed [31:0] r;
        begin
            r = 32'(d);
            if (r < 0)
                r = r + 32'sd360000000;
            if (r < 0)
                r = r + 32'sd360000000;
            if (r >= 32'sd360000000)
                r = r - 32'sd360000000;
            if (r >= 32'sd360000000)
                r = r - 32'sd360000000;
            if (r > 32'sd180000000)
                r = 32'sd360000000 - r;
            fold = r[29:0];
        end
    endfunction

    // Microdegrees to radians, rounded, sh = 32 for full or 33 for half angles.
    function automatic logic [CW-1:0] to_rad(input logic [29:0] m, input logic half);
        logic [69:0] p;
        logic [69:0] q;
        begin
            p = 70'(m) * 70'(RAD_PER_UDEG);
            if (half)
                q = (p + (70'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS);
            else
                q = (p + (70'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
            to_rad = q[CW-1:0];
        end
    endfunction

    // Stage one: differences and raw latitudes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= 31'(lat_a) - 31'(lat_b);
            d_reg[1] <= 31'(lon_a) - 31'(lon_b);
            d_reg[2] <= 31'(lat_a);
            d_reg[3] <= 31'(lat_b);
        end
    end

    // Stage two: fold and mirror latitudes above 90 degrees.
    always_ff @(posedge clk)
    begin
        logic [29:0] ma;
        logic [29:0] mb;
        if (en)
        begin
            ma = fold(d_reg[2]);
            mb = fold(d_reg[3]);
            f_reg[0] <= fold(d_reg[0]);
            f_reg[1] <= fold(d_reg[1]);
            f_reg[2] <= (ma > UDEG_QUARTER) ? UDEG_HALF - ma : ma;
            f_reg[3] <= (mb > UDEG_QUARTER) ? UDEG_HALF - mb : mb;
            n_reg <= {mb > UDEG_QUARTER, ma > UDEG_QUARTER};
        end
    end

    // Stage three: radians.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= to_rad(f_reg[0], 1'b1);
            t_reg[1] <= to_rad(f_reg[1], 1'b1);
            t_reg[2] <= to_rad(f_reg[2], 1'b0);
            t_reg[3] <= to_rad(f_reg[3], 1'b0);
            nd_reg <= n_reg[0] ^ n_reg[1];
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[1:0], in_valid};
    end

    assign out_valid = v_reg[2];
    assign th_dlat = t_reg[0];
    assign th_dlon = t_reg[1];
    assign th_la = t_reg[2];
    assign th_lb = t_reg[3];
    assign neg_diff = nd_reg;

endmodule
`default_nettype wire

[hdl/hav_cordic.sv]
// Unrolled CORDIC pipeline, one register stage per iteration, rotation or vectoring mode.
// Depends on hav_pkg. Moves with the shared enable; carries no valid bits itself.
`default_nettype none
module hav_cordic
    import hav_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              vectoring,
    input  wire logic [CW-1:0]     x_in,
    input  wire logic [CW-1:0]     y_in,
    input  wire logic [CW-1:0]     z_in,
    output logic [CW-1:0]          x_out,
    output logic [CW-1:0]          y_out,
    output logic [CW-1:0]          z_out
);

    logic signed [CW-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] z_reg [CORDIC_STAGES+1];

    always_comb
    begin
        x_reg[0] = x_in;
        y_reg[0] = y_in;
        z_reg[0] = z_in;
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic up;
        assign up = vectoring ? (y_reg[i] < 0) : (z_reg[i] >= 0);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (up)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q(i);
                end
            end
        end
    end

    assign x_out = x_reg[CORDIC_STAGES];
    assign y_out = y_reg[CORDIC_STAGES];
    assign z_out = z_reg[CORDIC_STAGES];

endmodule
`default_nettype wire

[hdl/hav_sqrt.sv]
// Pipelined restoring square root, one result bit per register stage.
// Depends on hav_pkg. Input is a Q(F) value in 0..1; output is floor(sqrt(v * 2^F)).
`default_nettype none
module hav_sqrt
    import hav_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [FRAC_BITS:0]    v_in,
    output logic [FRAC_BITS:0]         root
);

    logic [SQ_W-1:0] rad_reg [ROOT_STEPS+1];
    logic [SQ_W:0] rem_reg [ROOT_STEPS+1];
    logic [FRAC_BITS:0] r_reg [ROOT_STEPS+1];

    always_comb
    begin
        rad_reg[0] = SQ_W'(v_in) << FRAC_BITS;
        rem_reg[0] = '0;
        r_reg[0] = '0;
    end

    // One result bit per stage, most significant first.
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_step
        logic [SQ_W:0] rem_s;
        logic [SQ_W:0] trial;
        assign rem_s = {rem_reg[k][SQ_W-2:0], rad_reg[k][SQ_W-1 -: 2]};
        assign trial = (SQ_W+1)'({r_reg[k], 2'b01});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k+1] <= rad_reg[k] << 2;
                if (rem_s >= trial)
                begin
                    rem_reg[k+1] <= rem_s - trial;
                    r_reg[k+1] <= {r_reg[k][FRAC_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= rem_s;
                    r_reg[k+1] <= {r_reg[k][FRAC_BITS-1:0], 1'b0};
                end
            end
        end
    end

    assign root = r_reg[ROOT_STEPS];

endmodule
`default_nettype wire

[hdl/haversine_distance_top.sv]
// Haversine great-circle distance: pipeline of front end, CORDIC, square roots, output.
// Depends on hav_pkg, hav_front, hav_cordic and hav_sqrt.
//
// Usage: a transaction on the input channel (in_valid/in_ready) carries two points,
// lat_a, lon_a, lat_b, lon_b in signed microdegrees. Each one yields exactly one
// transaction on the output channel (out_valid/out_ready) with meters, the distance
// truncated to whole meters on a sphere of radius 6371000 m.
// An item passes 97 register stages: 3 front-end stages, 28 rotation CORDIC stages,
// 5 product stages, 31 square-root stages, 28 vectoring CORDIC stages and 2 scale
// stages, the last of which is the output register. Throughput is one transaction
// per cycle while the receiver does not stall; it is set by the fully unrolled
// pipeline, in which every CORDIC iteration and root bit has its own register stage.
// The whole pipeline advances on one enable. When the receiver stalls with a result
// waiting, the pipeline holds until that output register frees, so nothing is lost
// or repeated; in_ready is low only while the output holds a result that is not taken.
// Reset clears all valid bits; no item is in flight after reset.
`default_nettype none
module haversine_distance_top
    import hav_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [27:0]  lat_a,
    input  wire logic signed [28:0]  lon_a,
    input  wire logic signed [27:0]  lat_b,
    input  wire logic signed [28:0]  lon_b,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [24:0]              meters
);

    // Stages between the front end and the output register.
    localparam int MID_STAGES = CORDIC_STAGES + 5 + ROOT_STEPS + CORDIC_STAGES + 1;

    logic en;
    logic fv;
    logic [CW-1:0] th [4];
    logic nd;
    logic [CW-1:0] cx [4];
    logic [CW-1:0] cy [4];
    logic [CW-1:0] cz [4];
    logic [MID_STAGES-1:0] v_reg;
    logic [CORDIC_STAGES-1:0] nd_pipe_reg;
    logic out_valid_reg;
    logic [24:0] meters_reg;

    // The whole pipeline moves unless a result sits unconsumed at the output.
    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    hav_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
        .out_valid(fv), .th_dlat(th[0]), .th_dlon(th[1]), .th_la(th[2]), .th_lb(th[3]),
        .neg_diff(nd)
    );

    // Four rotation CORDICs: sin of half differences, cos of latitudes.
    for (genvar j = 0; j < 4; j++)
    begin : g_rot
        hav_cordic u_rot (
            .clk(clk), .en(en), .vectoring(1'b0),
            .x_in(GAIN_Q), .y_in('0), .z_in(th[j]),
            .x_out(cx[j]), .y_out(cy[j]), .z_out(cz[j])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
            nd_pipe_reg <= {nd_pipe_reg[CORDIC_STAGES-2:0], nd};
    end

    // Product stages: clamped CORDIC outputs, squares and cos product, its product with sin^2, a, then 1 - a.
    logic [FRAC_BITS:0] sl_reg, so_reg, ca_reg, cb_reg;
    logic [FRAC_BITS:0] sl2_reg, so2_reg, cc_reg;
    logic [FRAC_BITS:0] sl2b_reg, t_reg;
    logic [FRAC_BITS:0] a_reg;
    logic [FRAC_BITS:0] b_reg, a2_reg;
    logic nd1_reg, nd2_reg, nd3_reg;
    logic [2*FRAC_BITS+1:0] p_sl, p_so, p_cc, p_t;
    logic [FRAC_BITS+1:0] sum_a;

    assign p_sl = sl_reg * sl_reg;
    assign p_so = so_reg * so_reg;
    assign p_cc = ca_reg * cb_reg;
    assign p_t = cc_reg * so2_reg;
    assign sum_a = (FRAC_BITS+2)'(sl2b_reg) + (FRAC_BITS+2)'(t_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl_reg <= clamp_one(cy[0]);
            so_reg <= clamp_one(cy[1]);
            ca_reg <= clamp_one(cx[2]);
            cb_reg <= clamp_one(cx[3]);
            nd1_reg <= nd_pipe_reg[CORDIC_STAGES-1];
            sl2_reg <= p_sl[2*FRAC_BITS:FRAC_BITS];
            so2_reg <= p_so[2*FRAC_BITS:FRAC_BITS];
            cc_reg <= p_cc[2*FRAC_BITS:FRAC_BITS];
            nd2_reg <= nd1_reg;
            sl2b_reg <= sl2_reg;
            t_reg <= p_t[2*FRAC_BITS:FRAC_BITS];
            nd3_reg <= nd2_reg;
            if (nd3_reg)
                a_reg <= (sl2b_reg >= t_reg) ? sl2b_reg - t_reg : '0;
            else if (sum_a > (FRAC_BITS+2)'(ONE_Q))
                a_reg <= (FRAC_BITS+1)'(ONE_Q);
            else
                a_reg <= sum_a[FRAC_BITS:0];
            a2_reg <= a_reg;
            b_reg <= (FRAC_BITS+1)'(ONE_Q) - a_reg;
        end
    end

    // Square roots of a and 1 - a.
    logic [FRAC_BITS:0] sa, sb;
    hav_sqrt u_sqa (.clk(clk), .en(en), .v_in(a2_reg), .root(sa));
    hav_sqrt u_sqb (.clk(clk), .en(en), .v_in(b_reg), .root(sb));

    // Vectoring CORDIC for atan2(sqrt(a), sqrt(1 - a)).
    logic [CW-1:0] vx, vy, vz;
    hav_cordic u_vec (
        .clk(clk), .en(en), .vectoring(1'b1),
        .x_in(CW'(sb)), .y_in(CW'(sa)), .z_in('0),
        .x_out(vx), .y_out(vy), .z_out(vz)
    );

    // Clamp the angle, then scale by the diameter.
    logic [FRAC_BITS:0] z_reg;
    logic [FRAC_BITS+25:0] scaled;
    logic signed [CW-1:0] vzs;
    assign vzs = vz;
    assign scaled = z_reg * TWO_R;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (vzs < 0)
                z_reg <= '0;
            else if (vzs > $signed(HALF_PI_Q))
                z_reg <= HALF_PI_Q[FRAC_BITS:0];
            else
                z_reg <= vzs[FRAC_BITS:0];
            meters_reg <= scaled[FRAC_BITS+24:FRAC_BITS];
        end
    end

    // Valid bits through the middle stages and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[MID_STAGES-2:0], fv};
            out_valid_reg <= v_reg[MID_STAGES-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign meters = meters_reg;

    // The pipeline stands still only while a result is waiting.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("pipeline stalled without a pending result");

    // A stalled result keeps its value.
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(meters))
        else $error("stalled result changed");

    // Results never exceed half the circumference.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> meters <= 25'd20015087)
        else $error("distance out of range");

endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for haversine_distance_top: directed table, then random point pairs.
// Depends on the RTL of the block (haversine_distance_top and its submodules) and nothing else.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int FRAC = 30;
    localparam int STAGES = 28;
    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 120;
    localparam longint unsigned PI_Q62 = 64'hC90FDAA22168C235;
    localparam longint FULL_TURN = 360000000;
    localparam longint HALF_TURN = 180000000;
    localparam longint QUARTER_TURN = 90000000;

    typedef struct {
        logic signed [27:0] la;
        logic signed [28:0] oa;
        logic signed [27:0] lb;
        logic signed [28:0] ob;
        logic [24:0]        dist_m;
        bit                 known;
    } route_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [27:0] lat_a;
    logic signed [28:0] lon_a;
    logic signed [27:0] lat_b;
    logic signed [28:0] lon_b;
    logic               out_valid;
    logic               out_ready;
    logic [24:0]        meters;

    // Arctangent table, CORDIC gain and pi/2 in Q2.30, built once at start.
    longint             arctan_q[STAGES];
    longint             gain_q;
    longint             half_pi_q;

    logic [24:0]        distance_q[$];
    route_row_t         routes[$];
    int                 failures;
    int                 sent_count;
    int                 result_count;
    int                 idle_cycles;
    bit                 hold_done;

    haversine_distance_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .lat_a     (lat_a),
        .lon_a     (lon_a),
        .lat_b     (lat_b),
        .lon_b     (lon_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .meters    (meters)
    );

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Q30 product, truncated.
    function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
        bit [127:0] p;
        begin
            p = {64'd0, a} * {64'd0, b};
            qmul = p[93:30];
        end
    endfunction

    // Exact bitwise integer square root of a 128-bit value.
    function automatic longint unsigned isqrt_wide(input bit [127:0] v);
        bit [127:0]      rem;
        bit [127:0]      trial;
        longint unsigned root;
        begin
            rem = '0;
            root = 0;
            for (int k = 63; k >= 0; k--)
            begin
                rem = (rem << 2) | v[2*k +: 2];
                trial = ({64'd0, root} << 2) | 128'd1;
                if (rem >= trial)
                begin
                    rem = rem - trial;
                    root = (root << 1) | 64'd1;
                end
                else
                    root = root << 1;
            end
            isqrt_wide = root;
        end
    endfunction

    // Builds the arctangent table from its power series, the gain and pi/2.
    function automatic void build_tables();
        longint          acc;
        longint          term;
        longint unsigned g2;
        longint unsigned root;
        longint unsigned k32;
        int              e;
        begin
            g2 = 64'd1 << 62;
            for (int i = 0; i < STAGES; i++)
            begin
                acc = 0;
                if (i == 0)
                    acc = longint'((PI_Q62 + 64'd2) >> 2);
                else
                begin
                    for (int k = 0; ; k++)
                    begin
                        e = 62 - i * (2 * k + 1);
                        if (e < 0)
                            break;
                        term = longint'((64'd1 << e) / longint'(2 * k + 1));
                        acc = (k % 2 == 1) ? acc - term : acc + term;
                    end
                end
                arctan_q[i] = longint'((longint'(acc) + (64'd1 << 31)) >> 32);
                g2 = g2 + (g2 >> (2 * i));
            end
            root = isqrt_wide({64'd0, g2});
            k32 = (64'd1 << 63) / root;
            gain_q = longint'((k32 + 64'd2) >> 2);
            half_pi_q = longint'((PI_Q62 + (64'd1 << 32)) >> 33);
        end
    endfunction

    // Reduces an angle in microdegrees into 0..180 degrees.
    function automatic longint fold_turn(input longint d);
        longint r;
        begin
            r = d % FULL_TURN;
            if (r < 0)
                r = r + FULL_TURN;
            if (r > HALF_TURN)
                r = FULL_TURN - r;
            fold_turn = r;
        end
    endfunction

    function automatic longint udeg_to_rad(input longint unsigned m, input int extra);
        longint unsigned c;
        int              sh;
        begin
            sh = 32 + extra;
            c = PI_Q62 / 64'd180000000;
            udeg_to_rad = longint'((m * c + (64'd1 << (sh - 1))) >> sh);
        end
    endfunction

    function automatic longint clamp_unit(input longint v);
        begin
            if (v < 0)
                clamp_unit = 0;
            else if (v > (longint'(1) << FRAC))
                clamp_unit = longint'(1) << FRAC;
            else
                clamp_unit = v;
        end
    endfunction

    // Rotation-mode CORDIC; returns cosine and sine clamped to 0..1.
    function automatic void cordic_rotate(input longint theta, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        begin
            x = gain_q;
            y = 0;
            z = theta;
            for (int i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - arctan_q[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + arctan_q[i];
                end
            end
            c = clamp_unit(x);
            s = clamp_unit(y);
        end
    endfunction

    // Vectoring-mode CORDIC; angle of (x, y) clamped to 0..pi/2.
    function automatic longint cordic_angle(input longint x0, input longint y0);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        begin
            x = x0;
            y = y0;
            z = 0;
            for (int i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + arctan_q[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - arctan_q[i];
                end
            end
            cordic_angle = z < 0 ? 0 : (z > half_pi_q ? half_pi_q : z);
        end
    endfunction

    // Great-circle distance in meters for one pair of points.
    function automatic logic [24:0] route_meters(input logic signed [27:0] la,
                                                 input logic signed [28:0] oa,
                                                 input logic signed [27:0] lb,
                                                 input logic signed [28:0] ob);
        longint          c;
        longint          sdlat;
        longint          sdlon;
        longint          ca;
        longint          cb;
        longint          ma;
        longint          mb;
        longint unsigned sl2;
        longint unsigned so2;
        longint unsigned t;
        longint unsigned a;
        longint unsigned b;
        longint unsigned sa;
        longint unsigned sb;
        longint unsigned one;
        longint unsigned z;
        bit              neg_a;
        bit              neg_b;
        begin
            one = 64'd1 << FRAC;
            cordic_rotate(udeg_to_rad(fold_turn(longint'(la) - longint'(lb)), 1), c, sdlat);
            cordic_rotate(udeg_to_rad(fold_turn(longint'(oa) - longint'(ob)), 1), c, sdlon);
            ma = fold_turn(longint'(la));
            neg_a = ma > QUARTER_TURN;
            if (neg_a)
                ma = HALF_TURN - ma;
            cordic_rotate(udeg_to_rad(ma, 0), ca, c);
            mb = fold_turn(longint'(lb));
            neg_b = mb > QUARTER_TURN;
            if (neg_b)
                mb = HALF_TURN - mb;
            cordic_rotate(udeg_to_rad(mb, 0), cb, c);
            sl2 = qmul(sdlat, sdlat);
            so2 = qmul(sdlon, sdlon);
            t = qmul(qmul(ca, cb), so2);
            // Latitudes on opposite sides of a pole subtract the longitude term.
            if (neg_a != neg_b)
                a = sl2 >= t ? sl2 - t : 0;
            else
                a = sl2 + t;
            if (a > one)
                a = one;
            b = one - a;
            sa = isqrt_wide({64'd0, a} << FRAC);
            sb = isqrt_wide({64'd0, b} << FRAC);
            z = cordic_angle(longint'(sb), longint'(sa));
            route_meters = 25'(qmul(z, 64'd12742000));
        end
    endfunction

    // Appends one route to the directed table.
    function automatic void add_route(input route_row_t r);
        begin
            routes.insert(routes.size(), r);
        end
    endfunction

    // Drives one transaction; valid stays high into the next one when it has no gap.
    task automatic send_route(input route_row_t r, input int gap);
        begin
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            lat_a <= r.la;
            lon_a <= r.oa;
            lat_b <= r.lb;
            lon_b <= r.ob;
            do
                @(posedge clk);
            while (!in_ready);
            distance_q.insert(distance_q.size(),
                              r.known ? r.dist_m : route_meters(r.la, r.oa, r.lb, r.ob));
            sent_count++;
        end
    endtask

    function automatic route_row_t random_route();
        route_row_t r;
        int         mode;
        begin
            mode = $urandom_range(0, 9);
            r.known = 1'b0;
            r.dist_m = '0;
            if (mode == 0)
            begin
                // Raw words over the full field width, out-of-range angles included.
                r.la = 28'($urandom);
                r.oa = 29'($urandom);
                r.lb = 28'($urandom);
                r.ob = 29'($urandom);
            end
            else
            begin
                r.la = 28'(longint'($urandom_range(0, 180000000)) - QUARTER_TURN);
                r.oa = 29'(longint'($urandom_range(0, 360000000)) - HALF_TURN);
                if (mode == 1)
                begin
                    // Nearby point: short distances.
                    r.lb = 28'(longint'(r.la) + longint'($urandom_range(0, 2000)) - 1000);
                    r.ob = 29'(longint'(r.oa) + longint'($urandom_range(0, 2000)) - 1000);
                end
                else
                begin
                    r.lb = 28'(longint'($urandom_range(0, 180000000)) - QUARTER_TURN);
                    r.ob = 29'(longint'($urandom_range(0, 360000000)) - HALF_TURN);
                end
            end
            random_route = r;
        end
    endfunction

    function automatic route_row_t row(input longint la, input longint oa, input longint lb,
                                       input longint ob, input int exp_m, input bit known);
        route_row_t r;
        begin
            r.la = 28'(la);
            r.oa = 29'(oa);
            r.lb = 28'(lb);
            r.ob = 29'(ob);
            r.dist_m = 25'(exp_m);
            r.known = known;
            row = r;
        end
    endfunction

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (distance_q.size() == 0)
                begin
                    $error("meters: no result expected, actual %0d", meters);
                    failures++;
                end
                else
                begin
                    if (meters !== distance_q[0])
                    begin
                        $error("meters: expected %0d, actual %0d", distance_q[0], meters);
                        failures++;
                    end
                    void'(distance_q.pop_front());
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Receiver: random stalls, and one long hold-off that fills the pipeline.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && result_count >= 200)
            begin
                hold_done = 1'b1;
                stall = 400;
            end
            else if ($urandom_range(0, 3) == 0)
                stall = 0;
            else
                stall = $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int gap;
        failures = 0;
        sent_count = 0;
        result_count = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        lat_a = '0;
        lon_a = '0;
        lat_b = '0;
        lon_b = '0;
        build_tables();

        // Directed routes: identical points, extremes, antipodes, poles, dateline,
        // raw field extremes outside the legal range.
        add_route(row(0, 0, 0, 0, 0, 1'b1));
        add_route(row(45000000, 90000000, 45000000, 90000000, 0, 1'b1));
        add_route(row(-90000000, -180000000, -90000000, -180000000, 0, 1'b1));
        add_route(row(0, 0, 0, 180000000, 0, 1'b0));
        add_route(row(90000000, 0, -90000000, 0, 0, 1'b0));
        add_route(row(90000000, 0, 90000000, 180000000, 0, 1'b0));
        add_route(row(0, -180000000, 0, 180000000, 0, 1'b0));
        add_route(row(0, 179999999, 0, -179999999, 0, 1'b0));
        add_route(row(-90000000, -180000000, 90000000, 180000000, 0, 1'b0));
        add_route(row(45000000, -90000000, -45000000, 90000000, 0, 1'b0));
        add_route(row(0, 0, 1, 1, 0, 1'b0));
        add_route(row(134217727, 268435455, -134217728, -268435456, 0, 1'b0));
        add_route(row(-134217728, -268435456, 134217727, 268435455, 0, 1'b0));
        add_route(row(100000000, 0, 80000000, 0, 0, 1'b0));
        add_route(row(-1, -1, -1, 0, 0, 1'b0));
        add_route(row(52520000, 13405000, 48856000, 2352000, 0, 1'b0));
        add_route(row(89999999, 0, 89999999, 179999999, 0, 1'b0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (routes[i])
            send_route(routes[i], $urandom_range(0, 6));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // One pause: drain every outstanding result before going on.
            if (n == 600)
            begin
                in_valid <= 1'b0;
                while (distance_q.size() > 0)
                    @(posedge clk);
            end
            // Some stretches run back to back with no gaps.
            gap = ((n / 100) % 3 == 0) ? 0 : $urandom_range(0, 6);
            send_route(random_route(), gap);
        end
        in_valid <= 1'b0;

        while (distance_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d point pairs (directed and random, legal and raw-width angles),",
                 sent_count);
        $display("checked %0d distances under random stalls and one long receiver hold-off.",
                 result_count);
        if (failures == 0 && distance_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
hdl/hav_pkg.sv
hdl/hav_front.sv
hdl/hav_cordic.sv
hdl/hav_sqrt.sv
hdl/haversine_distance_top.sv
test/testbench.sv
